>>> src/ncs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared types, codes and saturating Q16.16 helpers for the spline table.
// ----------------------------------------------------------------------------
package ncs_pkg;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

	localparam logic [2:0] CMD_EVAL   = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_DELETE = 3'd2;
	localparam logic [2:0] CMD_UPDATE = 3'd3;
	localparam logic [2:0] CMD_SETLIN = 3'd4;
	localparam logic [2:0] CMD_READ   = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;

	localparam logic signed [31:0] Q_ONE   = 32'sd65536;
	localparam logic signed [31:0] Q_TWO   = 32'sd131072;
	localparam logic signed [31:0] Q_THREE = 32'sd196608;
	localparam logic signed [31:0] Q_SIX   = 32'sd393216;
	localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

	// ceil(2^34 / 6): n / 6 = (n * Q_RECIP6) >> 34 for n < 2^32
	localparam logic [31:0] Q_RECIP6 = 32'hAAAA_AAAB;

	localparam logic signed [63:0] LIM_HI = 64'sd2147483647;
	localparam logic signed [63:0] LIM_LO = -64'sd2147483648;

	function automatic sat_t sat64(input logic signed [63:0] v);
		sat_t r;
		if (v > LIM_HI) begin
			r.ovf = 1'b1;
			r.val = Q_MAX;
		end else if (v < LIM_LO) begin
			r.ovf = 1'b1;
			r.val = Q_MIN;
		end else begin
			r.ovf = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

	function automatic sat_t qadd(input logic signed [31:0] a, input logic signed [31:0] b);
		return sat64(64'(a) + 64'(b));
	endfunction

	function automatic sat_t qsub(input logic signed [31:0] a, input logic signed [31:0] b);
		return sat64(64'(a) - 64'(b));
	endfunction

	// dividend for a Q16.16 quotient: a * 2^16
	function automatic logic signed [63:0] qnum(input logic signed [31:0] a);
		return {{16{a[31]}}, a, 16'h0000};
	endfunction

endpackage

>>> src/natural_cubic_spline_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// natural_cubic_spline_table_core
// Sorted Q16.16 knot table with natural cubic spline evaluation.
//
// Input channel (in_valid / in_stall) takes one command item; the block
// takes one item at a time and holds in_stall high while it works on it.
// Output channel (out_valid / out_stall) returns exactly one result item per
// command from an output register; the next command may be taken while that
// result waits to be taken, and the block waits at its end if it still does.
// Knots, second derivatives and sweep scratch live in four RAMs with a
// registered read; a sequencer drives one shared 32x32 multiplier, one
// radix-2 divider and a reciprocal divide by six. Evaluate runs up to 5
// quotients and 18 products in series plus the linear segment search;
// insert and delete shift the table and then recompute the second
// derivatives, with 6 quotients per interior knot.
// Reset clears the knot count and the handshakes; table contents stay
// undefined until written.
// ----------------------------------------------------------------------------
module natural_cubic_spline_table_core
	import ncs_pkg::*;
#(
	parameter int MAX_POINTS = 16,
	localparam int AW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(MAX_POINTS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           cmd,
	input  logic signed [31:0]   point_x,
	input  logic signed [31:0]   point_y,
	input  logic signed [31:0]   second_x,
	input  logic signed [31:0]   second_y,
	input  logic [3:0]           point_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   value,
	output logic signed [31:0]   tangent,
	output logic signed [31:0]   read_x,
	output logic signed [31:0]   read_y,
	output logic [CW-1:0]        count,
	output logic [1:0]           status
);

	localparam int XW = (CW > 4) ? CW : 4;
	localparam int EW = CW + 1;

	typedef enum logic [6:0] {
		S_IDLE, S_DISPATCH, S_DONE,
		S_MUL, S_MUL2, S_DIV0, S_DIV1, S_DIV2, S_SIX0, S_SIX1,
		S_F0, S_F1, S_F2,
		S_I0, S_I1, S_I2, S_I3,
		S_D1, S_D2, S_D3,
		S_U0, S_L0, S_L1, S_RD0, S_RD1,
		S_R_INIT, S_R_A0, S_R_A1, S_R_A2, S_R_A3,
		S_R_C0, S_R_C1, S_R_C2, S_R_C3, S_R_C4, S_R_C5, S_R_C6, S_R_C7, S_R_C8, S_R_C9,
		S_R_BK, S_R_B0, S_R_B1, S_R_B2,
		S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_E8,
		S_V0, S_V1, S_V2, S_V3, S_V4, S_V5, S_V6, S_V7, S_V8, S_V9, S_V10,
		S_V11, S_V12, S_V13,
		S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8, S_T9, S_T10,
		S_T11, S_T12, S_T13
	} state_t;

	state_t state_q, ret_q;

	logic [2:0]         cmd_q;
	logic signed [31:0] px_q, py_q, qx_q, qy_q;
	logic [3:0]         idx_q;
	logic [CW-1:0]      cnt_q, i_q, j_q, b_q, bt_q;
	logic               ign_q, sat_q, mraw_q;

	logic signed [31:0] ma_q, mb_q, res_q;
	logic signed [63:0] prod_q, num_q;
	logic signed [31:0] den_q;
	logic [63:0]        quo_q;
	logic [31:0]        rem_q, dmag_q;
	logic               neg_q;
	logic [5:0]         dcnt_q;
	logic [31:0]        six_mag_q;
	logic               six_neg_q;
	logic [63:0]        six_p_q;

	logic signed [31:0] xm_q, xi_q, xp_q, ym_q, yi_q, yp_q, dm_q, di_q;
	logic signed [31:0] span_q, sig_q, p_q, sdi_q, dprev_q, uprev_q, dnext_q;
	logic signed [31:0] e1_q, e2_q, h_q, a_q, c_q, ta_q, tc_q;
	logic signed [31:0] ev_value_q, ev_tan_q, rd_x_q, rd_y_q;

	logic               out_valid_q;
	logic signed [31:0] value_q, tangent_q, read_x_q, read_y_q;
	logic [CW-1:0]      count_q;
	logic [1:0]         status_q;

	logic [AW-1:0]      raddr, xy_waddr, su_waddr;
	logic               xy_we, sd_we, u_we;
	logic [31:0]        x_wd, y_wd, sd_wd, u_wd;
	logic [31:0]        x_rd, y_rd, sd_rd, u_rd;

	logic [32:0]        div_t, div_sub;
	logic               div_ge;
	logic signed [63:0] mul_adj, mul_sh;
	sat_t               mul_res, bsum;
	logic               idx_ok;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign tangent   = tangent_q;
	assign read_x    = read_x_q;
	assign read_y    = read_y_q;
	assign count     = count_q;
	assign status    = status_q;

	assign div_t   = {rem_q, quo_q[63]};
	assign div_ge  = (div_t >= {1'b0, dmag_q});
	assign div_sub = div_t - {1'b0, dmag_q};
	assign mul_adj = prod_q + (prod_q[63] ? 64'sd65535 : 64'sd0);
	assign mul_sh  = mul_adj >>> 16;
	assign mul_res = sat64(mul_sh);
	assign bsum    = qadd(res_q, e1_q);
	assign idx_ok  = (XW'(idx_q) < XW'(cnt_q));

	ncs_ram #(.W(32), .D(MAX_POINTS)) u_knot_x (
		.clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(x_wd), .raddr(raddr), .rdata(x_rd)
	);
	ncs_ram #(.W(32), .D(MAX_POINTS)) u_knot_y (
		.clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(y_wd), .raddr(raddr), .rdata(y_rd)
	);
	ncs_ram #(.W(32), .D(MAX_POINTS)) u_second_deriv (
		.clk(clk), .we(sd_we), .waddr(su_waddr), .wdata(sd_wd), .raddr(raddr), .rdata(sd_rd)
	);
	ncs_ram #(.W(32), .D(MAX_POINTS)) u_sweep_scratch (
		.clk(clk), .we(u_we), .waddr(su_waddr), .wdata(u_wd), .raddr(raddr), .rdata(u_rd)
	);

	always_comb begin
		raddr    = '0;
		xy_we    = 1'b0;
		xy_waddr = '0;
		x_wd     = '0;
		y_wd     = '0;
		sd_we    = 1'b0;
		u_we     = 1'b0;
		su_waddr = '0;
		sd_wd    = '0;
		u_wd     = '0;
		case (state_q)
			S_R_INIT: begin
				sd_we = 1'b1;
				u_we  = 1'b1;
			end
			S_R_A0: raddr = AW'(i_q - CW'(1));
			S_R_A1: raddr = AW'(i_q);
			S_R_A2: raddr = AW'(i_q + CW'(1));
			S_R_C3: begin
				sd_we    = 1'b1;
				su_waddr = AW'(i_q);
				sd_wd    = res_q;
			end
			S_R_C9: begin
				u_we     = 1'b1;
				su_waddr = AW'(i_q);
				u_wd     = res_q;
			end
			S_R_BK: begin
				sd_we    = 1'b1;
				su_waddr = AW'(cnt_q - CW'(1));
			end
			S_R_B0: raddr = AW'(i_q - CW'(1));
			S_R_B2: begin
				sd_we    = 1'b1;
				su_waddr = AW'(i_q - CW'(1));
				sd_wd    = bsum.val;
			end
			S_F1: raddr = AW'(b_q);
			S_I1: raddr = AW'(j_q - CW'(1));
			S_I2: begin
				xy_we    = 1'b1;
				xy_waddr = AW'(j_q);
				x_wd     = x_rd;
				y_wd     = y_rd;
			end
			S_I3: begin
				xy_we    = 1'b1;
				xy_waddr = AW'(b_q);
				x_wd     = px_q;
				y_wd     = py_q;
				sd_we    = 1'b1;
			end
			S_D1: raddr = AW'(j_q + CW'(1));
			S_D2: begin
				xy_we    = 1'b1;
				xy_waddr = AW'(j_q);
				x_wd     = x_rd;
				y_wd     = y_rd;
			end
			S_U0: begin
				xy_we    = 1'b1;
				xy_waddr = AW'(idx_q);
				x_wd     = px_q;
				y_wd     = py_q;
			end
			S_L0: begin
				xy_we    = 1'b1;
				x_wd     = px_q;
				y_wd     = py_q;
				sd_we    = 1'b1;
			end
			S_L1: begin
				xy_we    = 1'b1;
				xy_waddr = AW'(1);
				x_wd     = qx_q;
				y_wd     = qy_q;
				sd_we    = 1'b1;
				su_waddr = AW'(1);
			end
			S_RD0: raddr = AW'(idx_q);
			S_E3: raddr = AW'(bt_q - CW'(1));
			S_E4: raddr = AW'(bt_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		sat_t s1, s2;
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			mraw_q      <= 1'b0;
		end else begin
			s1 = '0;
			s2 = '0;
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q      <= cmd;
						px_q       <= point_x;
						py_q       <= point_y;
						qx_q       <= second_x;
						qy_q       <= second_y;
						idx_q      <= point_index;
						ign_q      <= 1'b0;
						sat_q      <= 1'b0;
						ev_value_q <= '0;
						ev_tan_q   <= '0;
						rd_x_q     <= '0;
						rd_y_q     <= '0;
						state_q    <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (cmd_q)
						CMD_EVAL: state_q <= S_E0;
						CMD_INSERT: begin
							if (cnt_q >= CW'(MAX_POINTS)) begin
								ign_q   <= 1'b1;
								state_q <= S_DONE;
							end else begin
								ret_q   <= S_I0;
								state_q <= S_F0;
							end
						end
						CMD_DELETE: begin
							j_q     <= CW'(idx_q);
							ign_q   <= !idx_ok;
							state_q <= idx_ok ? S_D1 : S_DONE;
						end
						CMD_UPDATE: begin
							ign_q   <= !idx_ok;
							state_q <= idx_ok ? S_U0 : S_DONE;
						end
						CMD_SETLIN: state_q <= S_L0;
						CMD_READ: begin
							ign_q   <= !idx_ok;
							state_q <= idx_ok ? S_RD0 : S_DONE;
						end
						default: begin
							ign_q   <= 1'b1;
							state_q <= S_DONE;
						end
					endcase
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						value_q     <= ev_value_q;
						tangent_q   <= ev_tan_q;
						read_x_q    <= rd_x_q;
						read_y_q    <= rd_y_q;
						count_q     <= cnt_q;
						status_q    <= ign_q ? ST_IGNORED : (sat_q ? ST_SAT : ST_OK);
						state_q     <= S_IDLE;
					end
				end

				// shared multiplier
				S_MUL: begin
					prod_q  <= ma_q * mb_q;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					res_q   <= mul_res.val;
					sat_q   <= sat_q | (mul_res.ovf & !mraw_q);
					mraw_q  <= 1'b0;
					state_q <= ret_q;
				end

				// shared divider, truncating toward zero
				S_DIV0: begin
					if (den_q == 32'sd0) begin
						sat_q   <= 1'b1;
						res_q   <= (num_q > 64'sd0) ? Q_MAX : ((num_q < 64'sd0) ? Q_MIN : 32'sd0);
						state_q <= ret_q;
					end else begin
						neg_q   <= num_q[63] ^ den_q[31];
						quo_q   <= num_q[63] ? (~num_q + 64'd1) : num_q;
						dmag_q  <= den_q[31] ? (~den_q + 32'd1) : den_q;
						rem_q   <= '0;
						dcnt_q  <= '0;
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					rem_q  <= div_ge ? div_sub[31:0] : div_t[31:0];
					quo_q  <= {quo_q[62:0], div_ge};
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd63) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (!neg_q && quo_q > 64'h0000_0000_7FFF_FFFF) begin
						res_q <= Q_MAX;
						sat_q <= 1'b1;
					end else if (neg_q && quo_q > 64'h0000_0000_8000_0000) begin
						res_q <= Q_MIN;
						sat_q <= 1'b1;
					end else begin
						res_q <= neg_q ? (~quo_q[31:0] + 32'd1) : quo_q[31:0];
					end
					state_q <= ret_q;
				end

				// divide by six, truncating toward zero
				S_SIX0: begin
					six_p_q <= 64'(six_mag_q) * 64'(Q_RECIP6);
					state_q <= S_SIX1;
				end
				S_SIX1: begin
					res_q   <= six_neg_q ? -$signed({2'b00, six_p_q[63:34]})
						: $signed({2'b00, six_p_q[63:34]});
					state_q <= ret_q;
				end

				// segment search: first knot with x not below px
				S_F0: begin
					b_q     <= '0;
					state_q <= (cnt_q == '0) ? ret_q : S_F1;
				end
				S_F1: state_q <= S_F2;
				S_F2: begin
					if ($signed(x_rd) < px_q) begin
						b_q     <= b_q + CW'(1);
						state_q <= (EW'(b_q) + EW'(1) < EW'(cnt_q)) ? S_F1 : ret_q;
					end else begin
						state_q <= ret_q;
					end
				end

				// insert
				S_I0: begin
					j_q     <= cnt_q;
					state_q <= S_I1;
				end
				S_I1: state_q <= (j_q == b_q) ? S_I3 : S_I2;
				S_I2: begin
					j_q     <= j_q - CW'(1);
					state_q <= S_I1;
				end
				S_I3: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= (cnt_q != '0) ? S_R_INIT : S_DONE;
				end

				// delete
				S_D1: state_q <= (EW'(j_q) + EW'(1) >= EW'(cnt_q)) ? S_D3 : S_D2;
				S_D2: begin
					j_q     <= j_q + CW'(1);
					state_q <= S_D1;
				end
				S_D3: begin
					cnt_q   <= cnt_q - CW'(1);
					state_q <= (cnt_q > CW'(2)) ? S_R_INIT : S_DONE;
				end

				S_U0: state_q <= (cnt_q > CW'(1)) ? S_R_INIT : S_DONE;
				S_L0: state_q <= S_L1;
				S_L1: begin
					cnt_q   <= CW'(2);
					state_q <= S_DONE;
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					rd_x_q  <= x_rd;
					rd_y_q  <= y_rd;
					state_q <= S_DONE;
				end

				// tridiagonal forward sweep
				S_R_INIT: begin
					dprev_q <= '0;
					uprev_q <= '0;
					i_q     <= CW'(1);
					state_q <= (cnt_q > CW'(2)) ? S_R_A0 : S_R_BK;
				end
				S_R_A0: state_q <= S_R_A1;
				S_R_A1: begin
					xm_q    <= x_rd;
					ym_q    <= y_rd;
					state_q <= S_R_A2;
				end
				S_R_A2: begin
					xi_q    <= x_rd;
					yi_q    <= y_rd;
					state_q <= S_R_A3;
				end
				S_R_A3: begin
					xp_q    <= x_rd;
					yp_q    <= y_rd;
					state_q <= S_R_C0;
				end
				S_R_C0: begin
					s1 = qsub(xp_q, xm_q);
					s2 = qsub(xi_q, xm_q);
					span_q  <= s1.val;
					sat_q   <= sat_q | s1.ovf | s2.ovf;
					num_q   <= qnum(s2.val);
					den_q   <= s1.val;
					ret_q   <= S_R_C1;
					state_q <= S_DIV0;
				end
				S_R_C1: begin
					sig_q   <= res_q;
					ma_q    <= res_q;
					mb_q    <= dprev_q;
					ret_q   <= S_R_C2;
					state_q <= S_MUL;
				end
				S_R_C2: begin
					s1 = qadd(res_q, Q_TWO);
					s2 = qsub(sig_q, Q_ONE);
					p_q     <= s1.val;
					sat_q   <= sat_q | s1.ovf | s2.ovf;
					num_q   <= qnum(s2.val);
					den_q   <= s1.val;
					ret_q   <= S_R_C3;
					state_q <= S_DIV0;
				end
				S_R_C3: begin
					s1 = qsub(yp_q, yi_q);
					s2 = qsub(xp_q, xi_q);
					sdi_q   <= res_q;
					sat_q   <= sat_q | s1.ovf | s2.ovf;
					num_q   <= qnum(s1.val);
					den_q   <= s2.val;
					ret_q   <= S_R_C4;
					state_q <= S_DIV0;
				end
				S_R_C4: begin
					s1 = qsub(yi_q, ym_q);
					s2 = qsub(xi_q, xm_q);
					e1_q    <= res_q;
					sat_q   <= sat_q | s1.ovf | s2.ovf;
					num_q   <= qnum(s1.val);
					den_q   <= s2.val;
					ret_q   <= S_R_C5;
					state_q <= S_DIV0;
				end
				S_R_C5: begin
					s1 = qsub(e1_q, res_q);
					sat_q   <= sat_q | s1.ovf;
					ma_q    <= Q_SIX;
					mb_q    <= s1.val;
					ret_q   <= S_R_C6;
					state_q <= S_MUL;
				end
				S_R_C6: begin
					num_q   <= qnum(res_q);
					den_q   <= span_q;
					ret_q   <= S_R_C7;
					state_q <= S_DIV0;
				end
				S_R_C7: begin
					e1_q    <= res_q;
					ma_q    <= sig_q;
					mb_q    <= uprev_q;
					ret_q   <= S_R_C8;
					state_q <= S_MUL;
				end
				S_R_C8: begin
					s1 = qsub(e1_q, res_q);
					sat_q   <= sat_q | s1.ovf;
					num_q   <= qnum(s1.val);
					den_q   <= p_q;
					ret_q   <= S_R_C9;
					state_q <= S_DIV0;
				end
				S_R_C9: begin
					uprev_q <= res_q;
					dprev_q <= sdi_q;
					i_q     <= i_q + CW'(1);
					state_q <= (EW'(i_q) + EW'(2) < EW'(cnt_q)) ? S_R_A0 : S_R_BK;
				end

				// back substitution
				S_R_BK: begin
					dnext_q <= '0;
					i_q     <= cnt_q - CW'(1);
					state_q <= S_R_B0;
				end
				S_R_B0: state_q <= S_R_B1;
				S_R_B1: begin
					e1_q    <= u_rd;
					ma_q    <= sd_rd;
					mb_q    <= dnext_q;
					ret_q   <= S_R_B2;
					state_q <= S_MUL;
				end
				S_R_B2: begin
					sat_q   <= sat_q | bsum.ovf;
					dnext_q <= bsum.val;
					i_q     <= i_q - CW'(1);
					state_q <= (i_q == CW'(1)) ? S_DONE : S_R_B0;
				end

				// evaluate
				S_E0: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else if (cnt_q == CW'(1)) begin
						state_q <= S_E1;
					end else begin
						ret_q   <= S_E2;
						state_q <= S_F0;
					end
				end
				S_E1: begin
					ev_value_q <= y_rd;
					ev_tan_q   <= y_rd;
					state_q    <= S_DONE;
				end
				S_E2: begin
					if (b_q == '0) begin
						bt_q <= CW'(1);
					end else if (b_q >= cnt_q) begin
						bt_q <= cnt_q - CW'(1);
					end else begin
						bt_q <= b_q;
					end
					state_q <= S_E3;
				end
				S_E3: state_q <= S_E4;
				S_E4: begin
					xm_q    <= x_rd;
					ym_q    <= y_rd;
					dm_q    <= sd_rd;
					state_q <= S_E5;
				end
				S_E5: begin
					xi_q    <= x_rd;
					yi_q    <= y_rd;
					di_q    <= sd_rd;
					state_q <= S_E6;
				end
				S_E6: begin
					if (cnt_q == CW'(2)) begin
						s1 = qsub(px_q, xm_q);
						s2 = qsub(yi_q, ym_q);
						sat_q   <= sat_q | s1.ovf | s2.ovf;
						ma_q    <= s1.val;
						mb_q    <= s2.val;
						mraw_q  <= 1'b1;
						ret_q   <= S_E7;
						state_q <= S_MUL;
					end else if (b_q == '0) begin
						ev_value_q <= ym_q;
						state_q    <= S_T0;
					end else if (b_q >= cnt_q) begin
						ev_value_q <= yi_q;
						state_q    <= S_T0;
					end else begin
						state_q <= S_V0;
					end
				end
				S_E7: begin
					s1 = qsub(xi_q, xm_q);
					sat_q   <= sat_q | s1.ovf;
					num_q   <= prod_q;
					den_q   <= s1.val;
					ret_q   <= S_E8;
					state_q <= S_DIV0;
				end
				S_E8: begin
					s1 = qadd(ym_q, res_q);
					sat_q      <= sat_q | s1.ovf;
					ev_value_q <= s1.val;
					state_q    <= S_T0;
				end

				// cubic value on segment
				S_V0: begin
					s1 = qsub(xi_q, xm_q);
					s2 = qsub(xi_q, px_q);
					h_q     <= s1.val;
					sat_q   <= sat_q | s1.ovf | s2.ovf;
					num_q   <= qnum(s2.val);
					den_q   <= s1.val;
					ret_q   <= S_V1;
					state_q <= S_DIV0;
				end
				S_V1: begin
					s1 = qsub(px_q, xm_q);
					a_q     <= res_q;
					sat_q   <= sat_q | s1.ovf;
					num_q   <= qnum(s1.val);
					den_q   <= h_q;
					ret_q   <= S_V2;
					state_q <= S_DIV0;
				end
				S_V2: begin
					c_q     <= res_q;
					ma_q    <= a_q;
					mb_q    <= a_q;
					ret_q   <= S_V3;
					state_q <= S_MUL;
				end
				S_V3: begin
					ma_q    <= res_q;
					mb_q    <= a_q;
					ret_q   <= S_V4;
					state_q <= S_MUL;
				end
				S_V4: begin
					s1 = qsub(res_q, a_q);
					ta_q    <= s1.val;
					sat_q   <= sat_q | s1.ovf;
					ma_q    <= c_q;
					mb_q    <= c_q;
					ret_q   <= S_V5;
					state_q <= S_MUL;
				end
				S_V5: begin
					ma_q    <= res_q;
					mb_q    <= c_q;
					ret_q   <= S_V6;
					state_q <= S_MUL;
				end
				S_V6: begin
					s1 = qsub(res_q, c_q);
					tc_q    <= s1.val;
					sat_q   <= sat_q | s1.ovf;
					ma_q    <= ta_q;
					mb_q    <= dm_q;
					ret_q   <= S_V7;
					state_q <= S_MUL;
				end
				S_V7: begin
					e1_q    <= res_q;
					ma_q    <= tc_q;
					mb_q    <= di_q;
					ret_q   <= S_V8;
					state_q <= S_MUL;
				end
				S_V8: begin
					s1 = qadd(e1_q, res_q);
					sat_q   <= sat_q | s1.ovf;
					ma_q    <= s1.val;
					mb_q    <= h_q;
					ret_q   <= S_V9;
					state_q <= S_MUL;
				end
				S_V9: begin
					ma_q    <= res_q;
					mb_q    <= h_q;
					ret_q   <= S_V10;
					state_q <= S_MUL;
				end
				S_V10: begin
					six_mag_q <= res_q[31] ? (~res_q + 32'd1) : res_q;
					six_neg_q <= res_q[31];
					ret_q     <= S_V11;
					state_q   <= S_SIX0;
				end
				S_V11: begin
					e1_q    <= res_q;
					ma_q    <= a_q;
					mb_q    <= ym_q;
					ret_q   <= S_V12;
					state_q <= S_MUL;
				end
				S_V12: begin
					e2_q    <= res_q;
					ma_q    <= c_q;
					mb_q    <= yi_q;
					ret_q   <= S_V13;
					state_q <= S_MUL;
				end
				S_V13: begin
					s1 = qadd(e2_q, res_q);
					s2 = qadd(s1.val, e1_q);
					sat_q      <= sat_q | s1.ovf | s2.ovf;
					ev_value_q <= s2.val;
					state_q    <= S_T0;
				end

				// slope on clamped segment
				S_T0: begin
					s1 = qsub(xi_q, xm_q);
					s2 = qsub(xi_q, px_q);
					h_q     <= s1.val;
					sat_q   <= sat_q | s1.ovf | s2.ovf;
					num_q   <= qnum(s2.val);
					den_q   <= s1.val;
					ret_q   <= S_T1;
					state_q <= S_DIV0;
				end
				S_T1: begin
					s1 = qsub(px_q, xm_q);
					a_q     <= res_q;
					sat_q   <= sat_q | s1.ovf;
					num_q   <= qnum(s1.val);
					den_q   <= h_q;
					ret_q   <= S_T2;
					state_q <= S_DIV0;
				end
				S_T2: begin
					s1 = qsub(yi_q, ym_q);
					c_q     <= res_q;
					sat_q   <= sat_q | s1.ovf;
					num_q   <= qnum(s1.val);
					den_q   <= h_q;
					ret_q   <= S_T3;
					state_q <= S_DIV0;
				end
				S_T3: begin
					e2_q    <= res_q;
					ma_q    <= Q_THREE;
					mb_q    <= a_q;
					ret_q   <= S_T4;
					state_q <= S_MUL;
				end
				S_T4: begin
					ma_q    <= res_q;
					mb_q    <= a_q;
					ret_q   <= S_T5;
					state_q <= S_MUL;
				end
				S_T5: begin
					s1 = qsub(res_q, Q_ONE);
					sat_q   <= sat_q | s1.ovf;
					ma_q    <= s1.val;
					mb_q    <= h_q;
					ret_q   <= S_T6;
					state_q <= S_MUL;
				end
				S_T6: begin
					ma_q    <= res_q;
					mb_q    <= dm_q;
					ret_q   <= S_T7;
					state_q <= S_MUL;
				end
				S_T7: begin
					six_mag_q <= res_q[31] ? (~res_q + 32'd1) : res_q;
					six_neg_q <= res_q[31];
					ret_q     <= S_T8;
					state_q   <= S_SIX0;
				end
				S_T8: begin
					e1_q    <= res_q;
					ma_q    <= Q_THREE;
					mb_q    <= c_q;
					ret_q   <= S_T9;
					state_q <= S_MUL;
				end
				S_T9: begin
					ma_q    <= res_q;
					mb_q    <= c_q;
					ret_q   <= S_T10;
					state_q <= S_MUL;
				end
				S_T10: begin
					s1 = qsub(res_q, Q_ONE);
					sat_q   <= sat_q | s1.ovf;
					ma_q    <= s1.val;
					mb_q    <= h_q;
					ret_q   <= S_T11;
					state_q <= S_MUL;
				end
				S_T11: begin
					ma_q    <= res_q;
					mb_q    <= di_q;
					ret_q   <= S_T12;
					state_q <= S_MUL;
				end
				S_T12: begin
					six_mag_q <= res_q[31] ? (~res_q + 32'd1) : res_q;
					six_neg_q <= res_q[31];
					ret_q     <= S_T13;
					state_q   <= S_SIX0;
				end
				S_T13: begin
					s1 = qsub(e2_q, e1_q);
					s2 = qadd(s1.val, res_q);
					sat_q    <= sat_q | s1.ovf | s2.ovf;
					ev_tan_q <= s2.val;
					state_q  <= S_DONE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> src/ncs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ncs_ram #(
	parameter int W = 32,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
